>>> rtl/core/c2dct_pkg.sv
package c2dct_pkg;

  // Fixed field widths
  localparam int DW        = 34;  // offset from centre or camera, signed
  localparam int NW        = 49;  // dividend bits of the zoom divider
  localparam int VW        = 41;  // divider result, signed
  localparam int ZW        = 24;  // zoom, unsigned Q8.16
  localparam int TW        = 16;  // cosine and sine, signed
  localparam int ZOOM_FRAC = 16;

  localparam logic [ZW-1:0] ZOOM_MIN = 24'd655;

  // Direction codes
  localparam logic OP_S2W = 1'b0;
  localparam logic OP_W2S = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_VIEW_WIDTH  = 3'd0;
  localparam logic [2:0] REG_VIEW_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ZOOM        = 3'd2;
  localparam logic [2:0] REG_COS         = 3'd3;
  localparam logic [2:0] REG_SIN         = 3'd4;
  localparam logic [2:0] REG_CAMERA_X    = 3'd5;
  localparam logic [2:0] REG_CAMERA_Y    = 3'd6;

  typedef struct packed {
    logic                 op;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } beat_t;

  typedef struct packed {
    logic        [ZW-1:0] zoom;
    logic signed [TW-1:0] cos_r;
    logic signed [TW-1:0] sin_r;
    logic signed [31:0]   cam_x;
    logic signed [31:0]   cam_y;
    logic signed [DW-1:0] cx_half;
    logic signed [DW-1:0] cy_half;
  } cfg_t;

endpackage

>>> rtl/core/c2dct_front.sv
module c2dct_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  c2dct_pkg::cfg_t    cfg,
  input  logic               q_full,
  output c2dct_pkg::beat_t   push
);
  import c2dct_pkg::*;

  logic  fv_r;
  item_t item_r;
  item_t item_nxt;
  logic signed [DW-1:0] ex;
  logic signed [DW-1:0] ey;

  // Take a beat whenever the holding register is empty or drains this cycle
  assign in_ready = !fv_r || !q_full;
  assign push.valid = fv_r;
  assign push.item  = item_r;

  // Classify: offset from viewport centre or from the camera
  always_comb begin
    ex = DW'(in_x);
    ey = DW'(in_y);
    item_nxt.op = in_op;
    if (in_op == OP_S2W) begin
      item_nxt.dx = ex - cfg.cx_half;
      item_nxt.dy = cfg.cy_half - ey;
    end else begin
      item_nxt.dx = ex - DW'(cfg.cam_x);
      item_nxt.dy = ey - DW'(cfg.cam_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> rtl/core/c2dct_fifo.sv
module c2dct_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  c2dct_pkg::beat_t push,
  output logic             full,
  input  logic             pop,
  output c2dct_pkg::beat_t head
);
  import c2dct_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t       mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full       = (cnt_r == (AW+1)'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rp_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push.item;
    end
  end

endmodule

>>> rtl/core/c2dct_div.sv
module c2dct_div (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  div_in,
  input  logic signed [c2dct_pkg::DW-1:0]       d,
  input  logic        [c2dct_pkg::ZW-1:0]       zoom,
  output logic signed [c2dct_pkg::VW-1:0]       q
);
  import c2dct_pkg::*;

  logic [NW-1:0] n_r   [NW+1];
  logic [ZW-1:0] r_r   [NW+1];
  logic          div_r [NW+1];
  logic          neg_r [NW+1];
  logic [NW-1:0] n_nxt [NW];
  logic [ZW-1:0] r_nxt [NW];
  logic [DW-1:0] mag;
  logic [NW-1:0] n0;
  logic signed [VW-1:0] qmag;
  logic signed [VW-1:0] q_r;
  logic [ZW:0]   trial [NW];
  logic          ge    [NW];

  // Prepare dividend: |d| * 2^16 plus half the divisor, or pass d through
  always_comb begin
    mag = d[DW-1] ? DW'(-d) : DW'(d);
    if (div_in) begin
      n0 = (NW'(mag) << ZOOM_FRAC) + NW'(zoom >> 1);
    end else begin
      n0 = NW'(d);
    end
  end

  // One restoring step per stage; quotient bits shift into the dividend
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      trial[i] = {r_r[i], n_r[i][NW-1]};
      ge[i]    = (trial[i] >= {1'b0, zoom});
      if (div_r[i]) begin
        r_nxt[i] = ge[i] ? ZW'(trial[i] - {1'b0, zoom}) : trial[i][ZW-1:0];
        n_nxt[i] = {n_r[i][NW-2:0], ge[i]};
      end else begin
        r_nxt[i] = r_r[i];
        n_nxt[i] = n_r[i];
      end
    end
  end

  assign qmag = VW'(n_r[NW]);
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= n0;
      r_r[0]   <= '0;
      div_r[0] <= div_in;
      neg_r[0] <= d[DW-1];
      for (int i = 0; i < NW; i++) begin
        n_r[i+1]   <= n_nxt[i];
        r_r[i+1]   <= r_nxt[i];
        div_r[i+1] <= div_r[i];
        neg_r[i+1] <= neg_r[i];
      end
      q_r <= (div_r[NW] && neg_r[NW]) ? -qmag : qmag;
    end
  end

endmodule

>>> rtl/core/c2dct_back.sv
module c2dct_back #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  c2dct_pkg::beat_t   head,
  output logic               pop,
  input  c2dct_pkg::cfg_t    cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic               out_saturated
);
  import c2dct_pkg::*;

  localparam int DL  = NW + 2;
  localparam int PRW = VW + TW;
  localparam int SW  = PRW + 1;
  localparam int RW  = SW - TRIG_FRAC_BITS;
  localparam int PW  = RW + ZW + 1;
  localparam logic signed [SW-1:0] RND_T = SW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [PW-1:0] RND_Z = PW'(1) << (ZOOM_FRAC - 1);
  localparam logic signed [PW-1:0] C_MAX = PW'(32'sh7fffffff);
  localparam logic signed [PW-1:0] C_MIN = PW'(32'sh80000000);

  logic en;
  logic vl_r [DL];
  logic op_r [DL];
  logic signed [VW-1:0] a;
  logic signed [VW-1:0] b;

  logic signed [PRW-1:0] pac_r, pbs_r, pbc_r, pas_r;
  logic v_m1_r, op_m1_r;
  logic signed [SW-1:0] sx, sy, tx, ty;
  logic signed [RW-1:0] rx_r, ry_r;
  logic v_s1_r, op_s1_r;
  logic signed [ZW:0]   zs;
  logic signed [PW-1:0] mx_nxt, my_nxt, mx_r, my_r;
  logic v_m2_r, op_m2_r;
  logic signed [PW-1:0] fx, fy;
  logic hi_x, lo_x, hi_y, lo_y;
  logic out_valid_r, sat_r;
  logic signed [31:0] ox_r, oy_r;

  // Whole back end advances unless the result register is held
  assign en  = !out_valid_r || out_ready;
  assign pop = en && head.valid;

  c2dct_div u_div_x (
    .clk    (clk),
    .en     (en),
    .div_in (head.item.op == OP_S2W),
    .d      (head.item.dx),
    .zoom   (cfg.zoom),
    .q      (a)
  );

  c2dct_div u_div_y (
    .clk    (clk),
    .en     (en),
    .div_in (head.item.op == OP_S2W),
    .d      (head.item.dy),
    .zoom   (cfg.zoom),
    .q      (b)
  );

  // Track valid and direction alongside the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        vl_r[i] <= 1'b0;
      end
      v_m1_r      <= 1'b0;
      v_s1_r      <= 1'b0;
      v_m2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vl_r[0] <= head.valid;
      for (int i = 1; i < DL; i++) begin
        vl_r[i] <= vl_r[i-1];
      end
      v_m1_r      <= vl_r[DL-1];
      v_s1_r      <= v_m1_r;
      v_m2_r      <= v_s1_r;
      out_valid_r <= v_m2_r;
    end
  end

  // Rotation sums, rounded to nearest with ties upward
  always_comb begin
    if (op_m1_r == OP_S2W) begin
      sx = SW'(pac_r) + SW'(pbs_r);
      sy = SW'(pbc_r) - SW'(pas_r);
    end else begin
      sx = SW'(pac_r) - SW'(pbs_r);
      sy = SW'(pas_r) + SW'(pbc_r);
    end
    tx = (sx + RND_T) >>> TRIG_FRAC_BITS;
    ty = (sy + RND_T) >>> TRIG_FRAC_BITS;
  end

  // Zoom product, or camera offset for screen to world
  always_comb begin
    zs = signed'({1'b0, cfg.zoom});
    if (op_s1_r == OP_W2S) begin
      mx_nxt = PW'(rx_r) * PW'(zs);
      my_nxt = PW'(ry_r) * PW'(zs);
    end else begin
      mx_nxt = PW'(rx_r) + PW'(cfg.cam_x);
      my_nxt = PW'(ry_r) + PW'(cfg.cam_y);
    end
  end

  // Re-centre and clip
  always_comb begin
    if (op_m2_r == OP_W2S) begin
      fx = PW'(cfg.cx_half) + ((mx_r + RND_Z) >>> ZOOM_FRAC);
      fy = PW'(cfg.cy_half) - ((my_r + RND_Z) >>> ZOOM_FRAC);
    end else begin
      fx = mx_r;
      fy = my_r;
    end
    hi_x = (fx > C_MAX);
    lo_x = (fx < C_MIN);
    hi_y = (fy > C_MAX);
    lo_y = (fy < C_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0] <= head.item.op;
      for (int i = 1; i < DL; i++) begin
        op_r[i] <= op_r[i-1];
      end
      pac_r   <= PRW'(a) * PRW'(cfg.cos_r);
      pbs_r   <= PRW'(b) * PRW'(cfg.sin_r);
      pbc_r   <= PRW'(b) * PRW'(cfg.cos_r);
      pas_r   <= PRW'(a) * PRW'(cfg.sin_r);
      op_m1_r <= op_r[DL-1];
      rx_r    <= RW'(tx);
      ry_r    <= RW'(ty);
      op_s1_r <= op_m1_r;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
      op_m2_r <= op_s1_r;
      ox_r    <= hi_x ? 32'sh7fffffff : (lo_x ? 32'sh80000000 : fx[31:0]);
      oy_r    <= hi_y ? 32'sh7fffffff : (lo_y ? 32'sh80000000 : fy[31:0]);
      sat_r   <= hi_x || lo_x || hi_y || lo_y;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_saturated = sat_r;

endmodule

>>> rtl/core/camera_2d_coordinate_transform.sv
// 2D camera transform between screen and world coordinates (Q24.8 points).
// Input channel: in_valid/in_ready with in_op (0 screen to world, 1 world
// to screen), in_x and in_y. Result channel: out_valid/out_ready with
// out_x, out_y and out_saturated, set when either coordinate was clipped.
// Registers are written over the APB-style port at byte address 4*index:
// view width, view height, zoom (Q8.16), cosine, sine (Q1.14), camera x/y.
// Write them only while no beat is in flight.
// Throughput: one point per cycle while the result channel is not stalled,
// with screen-to-world and world-to-screen points mixed freely. The
// 49-stage restoring divider for the zoom division makes up most of the
// pipeline; the rest is the front register, the queue, the rotation
// multiply and sum, the zoom multiply and the clip stage.
// Reset clears all valid state and loads the register reset values; no
// result is presented after reset until a point is accepted.
// When out_ready is low while out_valid is high, the result holds and the
// back pipeline halts; the four-entry queue and the front register keep
// taking points until they fill, then in_ready drops.
module camera_2d_coordinate_transform #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic               out_saturated
);
  import c2dct_pkg::*;

  localparam int CWW = 16 + COORD_FRAC_BITS;

  logic [15:0]        view_width_r;
  logic [15:0]        view_height_r;
  logic [ZW-1:0]      zoom_r;
  logic signed [15:0] cos_r;
  logic signed [15:0] sin_r;
  logic signed [31:0] cam_x_r;
  logic signed [31:0] cam_y_r;
  logic               wr_en;
  logic [CWW-1:0]     wsh;
  logic [CWW-1:0]     hsh;
  cfg_t               cfg;
  beat_t              push;
  beat_t              head;
  logic               q_full;
  logic               pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_width_r  <= 16'd1024;
      view_height_r <= 16'd768;
      zoom_r        <= 24'd65536;
      cos_r         <= 16'sd16384;
      sin_r         <= 16'sd0;
      cam_x_r       <= 32'sd0;
      cam_y_r       <= 32'sd0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_VIEW_WIDTH:  view_width_r  <= pwdata[15:0];
        REG_VIEW_HEIGHT: view_height_r <= pwdata[15:0];
        REG_ZOOM:        zoom_r        <= pwdata[ZW-1:0];
        REG_COS:         cos_r         <= pwdata[15:0];
        REG_SIN:         sin_r         <= pwdata[15:0];
        REG_CAMERA_X:    cam_x_r       <= pwdata;
        REG_CAMERA_Y:    cam_y_r       <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (paddr[4:2])
      REG_VIEW_WIDTH:  prdata = 32'(view_width_r);
      REG_VIEW_HEIGHT: prdata = 32'(view_height_r);
      REG_ZOOM:        prdata = 32'(zoom_r);
      REG_COS:         prdata = 32'(unsigned'(cos_r));
      REG_SIN:         prdata = 32'(unsigned'(sin_r));
      REG_CAMERA_X:    prdata = cam_x_r;
      REG_CAMERA_Y:    prdata = cam_y_r;
      default:         prdata = 32'd0;
    endcase
  end

  // Derived settings: clamped zoom and viewport centre
  always_comb begin
    wsh         = CWW'(view_width_r) << COORD_FRAC_BITS;
    hsh         = CWW'(view_height_r) << COORD_FRAC_BITS;
    cfg.zoom    = (zoom_r < ZOOM_MIN) ? ZOOM_MIN : zoom_r;
    cfg.cos_r   = cos_r;
    cfg.sin_r   = sin_r;
    cfg.cam_x   = cam_x_r;
    cfg.cam_y   = cam_y_r;
    cfg.cx_half = DW'(wsh >> 1);
    cfg.cy_half = DW'(hsh >> 1);
  end

  c2dct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_x     (in_x),
    .in_y     (in_y),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push)
  );

  c2dct_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  c2dct_back #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_saturated (out_saturated)
  );

  // No result straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A clipped result carries a limit value in one coordinate
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
       out_y == 32'sh7fffffff || out_y == 32'sh80000000))
    else $error("saturation flag without a clipped coordinate");

  // Queue never pops while empty
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue pop while empty");

endmodule
